### hw/rtl/tql_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tql_pkg: shared types and constants of the tabular Q-learning agent
// Transaction payload structs, controller command/status structs, register
// indexes, reset values and the feedback decode.
// ----------------------------------------------------------------------------
package tql_pkg;

  // Fixed field widths
  localparam int ACT_W     = 3;
  localparam int STATE_W   = 2;
  localparam int REWARD_W  = 4;
  localparam int PROB_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // Table geometry and Q format defaults
  localparam int NUM_STATES      = 4;
  localparam int NUM_ACTIONS_DEF = 7;
  localparam int Q_FRAC_BITS_DEF = 16;
  localparam int Q_INT_BITS      = 8;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA   = 1'd1;
  localparam logic [CFG_W-1:0]     LR_RESET    = 16'd6554;
  localparam logic [CFG_W-1:0]     GAMMA_RESET = 16'd58982;

  // Probability one in Q0.16, one bit wider than a probability
  localparam logic [PROB_W:0] PROB_ONE = 17'h10000;

  // Rewards
  localparam logic [REWARD_W-1:0] REWARD_BOTH = 4'd10;
  localparam logic [REWARD_W-1:0] REWARD_ONE  = 4'd5;
  localparam logic [REWARD_W-1:0] REWARD_NONE = 4'd0;

  // Next states
  localparam logic [STATE_W-1:0] ST_BOTH = 2'd0;
  localparam logic [STATE_W-1:0] ST_C    = 2'd1;
  localparam logic [STATE_W-1:0] ST_DV   = 2'd2;
  localparam logic [STATE_W-1:0] ST_NONE = 2'd3;

  // Opcodes
  localparam logic OP_SELECT   = 1'b0;
  localparam logic OP_FEEDBACK = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [PROB_W-1:0] rand_prob;
    logic [PROB_W-1:0] greedy_prob;
    logic [ACT_W-1:0]  random_action;
    logic              c_improved;
    logic              dv_improved;
  } in_item_t;

  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic                explored;
    logic [STATE_W-1:0]  next_state;
    logic [REWARD_W-1:0] reward;
    logic                saturated;
  } out_item_t;

  typedef struct packed {
    logic accept;     // latch the input transaction
    logic scan_clr;   // restart the row scan
    logic scan_rd;    // read the next row entry
    logic fetch_q;    // read the entry to update, gamma * maxQ
    logic ld_target;  // register target and current Q
    logic ld_diff;    // register |target - Q| and its sign
    logic ld_mul2;    // lr * |d|
    logic wr_q;       // write the updated entry, move state
    logic load_out;   // load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic opcode;
    logic explore;
    logic scan_last;
  } ctrl_status_t;

  // Improvement flags to next state
  function automatic logic [STATE_W-1:0] fb_state(input logic c, input logic dv);
    logic [STATE_W-1:0] s;
    if (c && dv) begin
      s = ST_BOTH;
    end else if (c) begin
      s = ST_C;
    end else if (dv) begin
      s = ST_DV;
    end else begin
      s = ST_NONE;
    end
    return s;
  endfunction

  // Improvement flags to reward
  function automatic logic [REWARD_W-1:0] fb_reward(input logic c, input logic dv);
    logic [REWARD_W-1:0] r;
    if (c && dv) begin
      r = REWARD_BOTH;
    end else if (c || dv) begin
      r = REWARD_ONE;
    end else begin
      r = REWARD_NONE;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/tql_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tql_ctrl: sequencer of the Q-learning agent
// Steps one transaction through row scan, Q fetch, update arithmetic and
// result hand-off; owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module tql_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire                   out_ready,
  input  tql_pkg::ctrl_status_t status,
  output tql_pkg::ctrl_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_START    = 4'd1;
  localparam logic [3:0] S_SCAN     = 4'd2;
  localparam logic [3:0] S_SCAN_END = 4'd3;
  localparam logic [3:0] S_FETCH    = 4'd4;
  localparam logic [3:0] S_TARGET   = 4'd5;
  localparam logic [3:0] S_DIFF     = 4'd6;
  localparam logic [3:0] S_MUL2     = 4'd7;
  localparam logic [3:0] S_WRITE    = 4'd8;
  localparam logic [3:0] S_FINISH   = 4'd9;

  logic [3:0] phase;
  logic [3:0] phase_next;
  logic       out_free;

  assign in_ready = (phase == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Next state and command decode
  always_comb begin
    phase_next = phase;
    cmd        = '0;
    unique case (phase)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          phase_next = S_START;
        end
      end
      S_START: begin
        cmd.scan_clr = 1'b1;
        if (status.opcode == tql_pkg::OP_SELECT && status.explore) begin
          phase_next = S_FINISH;
        end else begin
          phase_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.scan_last) begin
          phase_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        phase_next = (status.opcode == tql_pkg::OP_FEEDBACK) ? S_FETCH : S_FINISH;
      end
      S_FETCH: begin
        cmd.fetch_q = 1'b1;
        phase_next  = S_TARGET;
      end
      S_TARGET: begin
        cmd.ld_target = 1'b1;
        phase_next    = S_DIFF;
      end
      S_DIFF: begin
        cmd.ld_diff = 1'b1;
        phase_next  = S_MUL2;
      end
      S_MUL2: begin
        cmd.ld_mul2 = 1'b1;
        phase_next  = S_WRITE;
      end
      S_WRITE: begin
        cmd.wr_q   = 1'b1;
        phase_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          phase_next   = S_IDLE;
        end
      end
      default: begin
        phase_next = S_IDLE;
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/tql_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tql_datapath: Q table, row scan and update arithmetic
// Holds the Q table memory with per-entry valid bits, the agent state, the
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module tql_datapath #(
  parameter int NUM_ACTIONS = tql_pkg::NUM_ACTIONS_DEF,
  parameter int Q_FRAC_BITS = tql_pkg::Q_FRAC_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire  [tql_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [tql_pkg::CFG_W-1:0]        cfg_data,
  input  tql_pkg::in_item_t                in_data,
  input  tql_pkg::ctrl_cmd_t               cmd,
  output tql_pkg::ctrl_status_t            status,
  output tql_pkg::out_item_t               out_data
);

  localparam int QW     = tql_pkg::Q_INT_BITS + Q_FRAC_BITS;
  localparam int AW     = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
  localparam int DEPTH  = tql_pkg::NUM_STATES * NUM_ACTIONS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PW     = tql_pkg::PROB_W;

  // Configuration registers
  logic [tql_pkg::CFG_W-1:0] alpha;
  logic [tql_pkg::CFG_W-1:0] gamma;

  // Agent state
  logic [tql_pkg::STATE_W-1:0] current_state;
  logic [AW-1:0]               last_action;

  // Latched transaction
  tql_pkg::in_item_t item;
  logic              explore;

  // Q table
  logic [QW-1:0]     mem [DEPTH];
  logic [DEPTH-1:0]  valid;
  logic [QW-1:0]     rd_data;
  logic              rd_vld;
  logic [QW-1:0]     rd_q;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] upd_addr;

  // Scan
  logic [AW-1:0]               scan_idx;
  logic [tql_pkg::STATE_W-1:0] scan_row;
  logic                        cmp_en;
  logic [AW-1:0]               cmp_idx;
  logic [QW-1:0]               best_q;
  logic [AW-1:0]               best_a;

  // Update arithmetic
  logic [tql_pkg::STATE_W-1:0]  fb_ns;
  logic [tql_pkg::REWARD_W-1:0] fb_r;
  logic [PW+QW-1:0]             prod1;
  logic [QW:0]                  target;
  logic [QW:0]                  target_next;
  logic [QW-1:0]                q_cur;
  logic                         ge;
  logic [QW:0]                  mag;
  logic [PW+QW:0]               prod2;
  logic [QW:0]                  delta;
  logic [QW:0]                  q_up;
  logic [QW-1:0]                q_new;
  logic                         sat_next;
  logic                         sat;

  // Select decision
  logic [AW-1:0]   ra_sat;
  logic [AW-1:0]   sel_action;
  logic [PW:0]     prob_sum;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= tql_pkg::LR_RESET;
      gamma <= tql_pkg::GAMMA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tql_pkg::REG_ALPHA: alpha <= cfg_data;
        tql_pkg::REG_GAMMA: gamma <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input latch and explore test
  assign prob_sum = {1'b0, in_data.rand_prob} + {1'b0, in_data.greedy_prob};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item    <= in_data;
      explore <= (prob_sum > tql_pkg::PROB_ONE);
    end
  end

  assign fb_ns = tql_pkg::fb_state(item.c_improved, item.dv_improved);
  assign fb_r  = tql_pkg::fb_reward(item.c_improved, item.dv_improved);

  assign status.opcode    = item.opcode;
  assign status.explore   = explore;
  assign status.scan_last = (scan_idx == AW'(NUM_ACTIONS - 1));

  // Read address: the scanned row, or the entry under update
  assign scan_row = (item.opcode == tql_pkg::OP_FEEDBACK) ? fb_ns : current_state;
  assign upd_addr = ADDR_W'(int'(current_state) * NUM_ACTIONS + int'(last_action));
  assign rd_addr  = cmd.scan_rd ? ADDR_W'(int'(scan_row) * NUM_ACTIONS + int'(scan_idx))
                                : upd_addr;
  assign rd_en    = cmd.scan_rd || cmd.fetch_q;
  assign rd_q     = rd_vld ? rd_data : '0;

  // Table memory
  always_ff @(posedge clk) begin
    if (cmd.wr_q) begin
      mem[upd_addr] <= q_new;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Entry valid bits; an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.wr_q) begin
        valid[upd_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= valid[rd_addr];
      end
    end
  end

  // Row scan: first index holding the maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en <= 1'b0;
    end else begin
      cmp_en <= cmd.scan_rd;
    end
    cmp_idx <= scan_idx;
    if (cmd.scan_clr) begin
      scan_idx <= '0;
    end else if (cmd.scan_rd) begin
      scan_idx <= scan_idx + AW'(1);
    end
    if (cmp_en && (cmp_idx == '0 || rd_q > best_q)) begin
      best_q <= rd_q;
      best_a <= cmp_idx;
    end
  end

  // Update pipeline: gamma*maxQ, target, |d|, lr*|d|
  assign target_next = (QW+1)'({fb_r, {Q_FRAC_BITS{1'b0}}}) + {1'b0, prod1[PW +: QW]};
  assign delta       = prod2[PW +: QW+1];
  assign q_up        = {1'b0, q_cur} + delta;

  always_ff @(posedge clk) begin
    if (cmd.fetch_q) begin
      prod1 <= gamma * best_q;
    end
    if (cmd.ld_target) begin
      target <= target_next;
      q_cur  <= rd_q;
    end
    if (cmd.ld_diff) begin
      ge  <= (target >= {1'b0, q_cur});
      mag <= (target >= {1'b0, q_cur}) ? target - {1'b0, q_cur} : {1'b0, q_cur} - target;
    end
    if (cmd.ld_mul2) begin
      prod2 <= alpha * mag;
    end
  end

  // New Q value, clipped at the top of the range
  always_comb begin
    sat_next = 1'b0;
    if (ge) begin
      if (q_up[QW]) begin
        q_new    = '1;
        sat_next = 1'b1;
      end else begin
        q_new = q_up[QW-1:0];
      end
    end else begin
      q_new = q_cur - delta[QW-1:0];
    end
  end

  // Select: random action limited to the table, or the scanned best
  assign ra_sat     = (int'(item.random_action) >= NUM_ACTIONS) ? AW'(NUM_ACTIONS - 1)
                                                                : AW'(item.random_action);
  assign sel_action = explore ? ra_sat : best_a;

  // Agent state
  always_ff @(posedge clk) begin
    if (rst) begin
      current_state <= '0;
      last_action   <= '0;
    end else begin
      if (cmd.wr_q) begin
        current_state <= fb_ns;
      end
      if (cmd.load_out && item.opcode == tql_pkg::OP_SELECT) begin
        last_action <= sel_action;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_q) begin
      sat <= sat_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (item.opcode == tql_pkg::OP_SELECT) begin
        out_data.action     <= tql_pkg::ACT_W'(sel_action);
        out_data.explored   <= explore;
        out_data.next_state <= current_state;
        out_data.reward     <= tql_pkg::REWARD_NONE;
        out_data.saturated  <= 1'b0;
      end else begin
        out_data.action     <= tql_pkg::ACT_W'(last_action);
        out_data.explored   <= 1'b0;
        out_data.next_state <= current_state;
        out_data.reward     <= fb_r;
        out_data.saturated  <= sat;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/tabular_q_learning_agent.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tabular_q_learning_agent: epsilon-greedy tabular Q-learning agent
// Top level: joins the sequencer and the datapath.
// ----------------------------------------------------------------------------
// One transaction at a time. A select that explores skips the row scan; a
// greedy select and a feedback step through it, reading one Q entry per cycle
// through the table's single read port, and a feedback then passes through
// the two registered multiplies of the update. The result sits in an output
// register, so the next transaction is accepted while the previous result
// waits; a second result stalls until the first is taken. The Q table starts
// all zero through per-entry valid bits, with no clearing pass. Configuration
// writes take effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
module tabular_q_learning_agent #(
  parameter int NUM_ACTIONS = tql_pkg::NUM_ACTIONS_DEF,
  parameter int Q_FRAC_BITS = tql_pkg::Q_FRAC_BITS_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_we,
  input  wire  [tql_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [tql_pkg::CFG_W-1:0]      cfg_data,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  tql_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  wire                            out_ready,
  output tql_pkg::out_item_t             out_data
);

  tql_pkg::ctrl_cmd_t    cmd;
  tql_pkg::ctrl_status_t status;

  tql_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tql_datapath #(
    .NUM_ACTIONS (NUM_ACTIONS),
    .Q_FRAC_BITS (Q_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
